>>> rtl/core/psd_pkg.sv
`default_nettype none
package psd_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int T_FRAC     = 16;
    localparam int DIST_BITS  = 25;

    // Coordinate differences and dot products.
    localparam int DB   = COORD_BITS + 1;
    localparam int NB   = 2 * DB + 1;
    localparam int DENB = 2 * DB;
    localparam int NUMB = NB + T_FRAC;

    // Projection parameter magnitude and its split for the multipliers.
    localparam int QB  = DB + T_FRAC;
    localparam int QL  = (QB + 1) / 2;
    localparam int QH  = QB - QL;
    localparam int PLW = QL + 1 + DB;
    localparam int PHW = QH + 1 + DB;

    // Residual, its truncated magnitude and the radicand.
    localparam int RW      = DB + T_FRAC + 3;
    localparam int RM      = DB + 2 + FRAC_BITS;
    localparam int R_SHIFT = T_FRAC - FRAC_BITS;
    localparam int SW      = 2 * RM + 1;
    localparam int QS      = (SW + 1) / 2;
    localparam int RADB    = 2 * QS;
    localparam int RMW     = QS + 2;

    localparam logic [QB-1:0]        T_ONE    = QB'(1) << T_FRAC;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_SEG   = 2'd2
    } psd_cmd_t;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] begin_x;
        logic signed [COORD_BITS-1:0] begin_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [DIST_BITS-1:0]         bound;
    } psd_req_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 bound_held;
    } psd_rsp_t;

    typedef struct packed {
        logic signed [DB-1:0] wx;
        logic signed [DB-1:0] wy;
        logic signed [DB-1:0] dx;
        logic signed [DB-1:0] dy;
        logic [DIST_BITS-1:0] bound;
        logic                 zero_t;
        logic                 one_t;
        logic                 neg;
    } psd_side_t;

    typedef struct packed {
        psd_side_t       side;
        logic [DENB-1:0] den;
        logic [DENB-1:0] rem;
        logic [QB-1:0]   nlo;
        logic [QB-1:0]   q;
    } psd_div_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] bound;
        logic [RMW-1:0]       rem;
        logic [QS-1:0]        root;
        logic [RADB-1:0]      rad;
    } psd_sqrt_t;

endpackage
`default_nettype wire

>>> rtl/core/point_segment_distance_unit.sv
// A request beat passes the front stages, the divider stages, the residual stages,
// the square root stages and the output register on its way to its response beat.
// Throughput: one beat per cycle unless the consumer stalls a held response; the restoring
// divider and the square root are unrolled into one register stage per result bit.
// Reset clears every stage valid bit and the output valid; data registers are not reset.
`default_nettype none
module point_segment_distance_unit import psd_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire psd_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output psd_rsp_t      rsp
);

    // The whole pipeline moves as one. It holds only while a finished beat
    // sits in the output register and the consumer stalls; while it holds,
    // no request enters, even if bubbles sit in front of that register.
    logic en;

    logic [QB:0] div_valid;
    psd_div_t    div_beat [QB+1];

    logic [QS:0] sq_valid;
    psd_sqrt_t   sq_beat [QS+1];

    logic      rsp_valid_reg;
    psd_rsp_t  rsp_reg;
    psd_rsp_t  rsp_next;

    logic [DIST_BITS-1:0] dist_sat;

    assign en        = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !en;

    // Differences, dot products, and the projection setup: four stages.
    psd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prev_valid (req_valid),
        .req        (req),
        .valid      (div_valid[0]),
        .beat       (div_beat[0])
    );

    // Projection parameter |n| * 2^T_FRAC / |d|^2, one quotient bit per stage.
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        psd_div_stage u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (div_valid[i]),
            .prev_beat  (div_beat[i]),
            .valid      (div_valid[i+1]),
            .beat       (div_beat[i+1])
        );
    end

    // Clamp the parameter, form the residual vector and its squared length.
    psd_resid u_resid (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prev_valid (div_valid[QB]),
        .prev_beat  (div_beat[QB]),
        .valid      (sq_valid[0]),
        .beat       (sq_beat[0])
    );

    // Integer square root of the squared length, one root bit per stage.
    for (genvar i = 0; i < QS; i++)
    begin : g_sqrt
        psd_sqrt_stage u_sqrt (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (sq_valid[i]),
            .prev_beat  (sq_beat[i]),
            .valid      (sq_valid[i+1]),
            .beat       (sq_beat[i+1])
        );
    end

    // Saturate the distance, then take the smaller of it and the bound.
    always_comb
    begin
        if (|sq_beat[QS].root[QS-1:DIST_BITS])
        begin
            dist_sat = DIST_MAX;
        end
        else
        begin
            dist_sat = sq_beat[QS].root[DIST_BITS-1:0];
        end

        rsp_next.bound_held = (sq_beat[QS].bound <= dist_sat);
        rsp_next.distance   = rsp_next.bound_held ? sq_beat[QS].bound : dist_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= sq_valid[QS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // An unclamped division always leaves a remainder below the divisor.
    a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[QB] && !div_beat[QB].side.zero_t && !div_beat[QB].side.one_t
        |-> div_beat[QB].rem < div_beat[QB].den)
        else $error("divider remainder not below divisor");

    // The square root remainder never exceeds twice the root.
    a_sqrt_rem : assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[QS] |-> sq_beat[QS].rem <= RMW'({sq_beat[QS].root, 1'b0}))
        else $error("square root remainder out of range");

    // A distance below the bound can never be the saturated value.
    a_rsp_sat : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.bound_held |-> rsp.distance != DIST_MAX)
        else $error("unbounded response carries saturated distance");
`endif

endmodule
`default_nettype wire

>>> rtl/core/psd_front.sv
`default_nettype none
module psd_front import psd_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     prev_valid,
    input  wire psd_req_t req,
    output logic          valid,
    output psd_div_t      beat
);

    logic [3:0] v_reg;

    logic signed [DB-1:0] wx1_reg, wy1_reg, dx1_reg, dy1_reg;
    logic [1:0]           cmd1_reg;
    logic [DIST_BITS-1:0] bound1_reg;

    logic signed [2*DB-1:0] pnx2_reg, pny2_reg, pdx2_reg, pdy2_reg;
    logic signed [DB-1:0]   wx2_reg, wy2_reg, dx2_reg, dy2_reg;
    logic [1:0]             cmd2_reg;
    logic [DIST_BITS-1:0]   bound2_reg;

    logic signed [NB-1:0] n3_reg;
    logic [DENB-1:0]      den3_reg;
    logic signed [DB-1:0] wx3_reg, wy3_reg, dx3_reg, dy3_reg;
    logic [1:0]           cmd3_reg;
    logic [DIST_BITS-1:0] bound3_reg;

    psd_div_t beat_reg;

    logic [NB-1:0]   nmag;
    logic [NUMB-1:0] num;
    logic            is_point, is_line, is_seg, den_zero, n_pos, n_big;
    psd_div_t        beat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], prev_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx1_reg    <= DB'(req.point_x) - DB'(req.begin_x);
            wy1_reg    <= DB'(req.point_y) - DB'(req.begin_y);
            dx1_reg    <= DB'(req.end_x) - DB'(req.begin_x);
            dy1_reg    <= DB'(req.end_y) - DB'(req.begin_y);
            cmd1_reg   <= req.cmd;
            bound1_reg <= req.bound;

            pnx2_reg   <= dx1_reg * wx1_reg;
            pny2_reg   <= dy1_reg * wy1_reg;
            pdx2_reg   <= dx1_reg * dx1_reg;
            pdy2_reg   <= dy1_reg * dy1_reg;
            wx2_reg    <= wx1_reg;
            wy2_reg    <= wy1_reg;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            cmd2_reg   <= cmd1_reg;
            bound2_reg <= bound1_reg;

            n3_reg     <= NB'(pnx2_reg) + NB'(pny2_reg);
            den3_reg   <= DENB'(pdx2_reg) + DENB'(pdy2_reg);
            wx3_reg    <= wx2_reg;
            wy3_reg    <= wy2_reg;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            cmd3_reg   <= cmd2_reg;
            bound3_reg <= bound2_reg;

            beat_reg   <= beat_next;
        end
    end

    // The divider starts with the top bits already brought down, since the
    // quotient never needs more than QB bits.
    always_comb
    begin
        nmag     = n3_reg[NB-1] ? NB'(-n3_reg) : NB'(n3_reg);
        num      = {nmag, {T_FRAC{1'b0}}};
        is_point = (cmd3_reg == CMD_POINT);
        is_line  = (cmd3_reg == CMD_LINE);
        is_seg   = !is_point && !is_line;
        den_zero = (den3_reg == '0);
        n_pos    = !n3_reg[NB-1] && (n3_reg != '0);
        n_big    = (nmag >= NB'(den3_reg));

        beat_next             = '0;
        beat_next.side.wx     = wx3_reg;
        beat_next.side.wy     = wy3_reg;
        beat_next.side.dx     = dx3_reg;
        beat_next.side.dy     = dy3_reg;
        beat_next.side.bound  = bound3_reg;
        beat_next.side.zero_t = is_point || den_zero || (is_seg && !n_pos);
        beat_next.side.one_t  = is_seg && !den_zero && n_pos && n_big;
        beat_next.side.neg    = is_line && n3_reg[NB-1];
        beat_next.den         = den3_reg;
        beat_next.rem         = DENB'(num[NUMB-1:QB]);
        beat_next.nlo         = num[QB-1:0];
        beat_next.q           = '0;
    end

    assign valid = v_reg[3];
    assign beat  = beat_reg;

endmodule
`default_nettype wire

>>> rtl/core/psd_div_stage.sv
`default_nettype none
module psd_div_stage import psd_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     prev_valid,
    input  wire psd_div_t prev_beat,
    output logic          valid,
    output psd_div_t      beat
);

    logic     valid_reg;
    psd_div_t beat_reg;
    psd_div_t beat_next;

    logic [DENB:0] r2;
    logic [DENB:0] diff;
    logic          fits;

    always_comb
    begin
        r2   = {prev_beat.rem, prev_beat.nlo[QB-1]};
        diff = r2 - {1'b0, prev_beat.den};
        fits = (r2 >= {1'b0, prev_beat.den});

        beat_next     = prev_beat;
        beat_next.rem = fits ? diff[DENB-1:0] : r2[DENB-1:0];
        beat_next.nlo = {prev_beat.nlo[QB-2:0], 1'b0};
        beat_next.q   = {prev_beat.q[QB-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule
`default_nettype wire

>>> rtl/core/psd_resid.sv
`default_nettype none
module psd_resid import psd_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     prev_valid,
    input  wire psd_div_t prev_beat,
    output logic          valid,
    output psd_sqrt_t     beat
);

    logic [6:0] v_reg;

    logic [QB-1:0]        tm1_reg;
    logic                 neg1_reg;
    logic signed [DB-1:0] wx1_reg, wy1_reg, dx1_reg, dy1_reg;
    logic [DIST_BITS-1:0] bound1_reg;

    logic signed [PLW-1:0] plox2_reg, ploy2_reg;
    logic signed [PHW-1:0] phix2_reg, phiy2_reg;
    logic                  neg2_reg;
    logic signed [DB-1:0]  wx2_reg, wy2_reg;
    logic [DIST_BITS-1:0]  bound2_reg;

    logic signed [RW-1:0] px3_reg, py3_reg, ox3_reg, oy3_reg;
    logic                 neg3_reg;
    logic [DIST_BITS-1:0] bound3_reg;

    logic signed [RW-1:0] rx4_reg, ry4_reg;
    logic [DIST_BITS-1:0] bound4_reg;

    logic [RM-1:0]        mx5_reg, my5_reg;
    logic [DIST_BITS-1:0] bound5_reg;

    logic [2*RM-1:0]      sqx6_reg, sqy6_reg;
    logic [DIST_BITS-1:0] bound6_reg;

    psd_sqrt_t beat_reg;

    logic [QB-1:0]        tm1_next;
    logic signed [RW-1:0] absx, absy;
    logic [RM-1:0]        mx5_next, my5_next;
    logic [SW-1:0]        sum_next;

    always_comb
    begin
        priority if (prev_beat.side.zero_t)
        begin
            tm1_next = '0;
        end
        else if (prev_beat.side.one_t)
        begin
            tm1_next = T_ONE;
        end
        else
        begin
            tm1_next = prev_beat.q;
        end

        absx     = rx4_reg[RW-1] ? -rx4_reg : rx4_reg;
        absy     = ry4_reg[RW-1] ? -ry4_reg : ry4_reg;
        mx5_next = RM'($unsigned(absx) >> R_SHIFT);
        my5_next = RM'($unsigned(absy) >> R_SHIFT);
        sum_next = SW'(sqx6_reg) + SW'(sqy6_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], prev_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm1_reg    <= tm1_next;
            neg1_reg   <= prev_beat.side.neg;
            wx1_reg    <= prev_beat.side.wx;
            wy1_reg    <= prev_beat.side.wy;
            dx1_reg    <= prev_beat.side.dx;
            dy1_reg    <= prev_beat.side.dy;
            bound1_reg <= prev_beat.side.bound;

            // The parameter is split in halves so no product gets too wide.
            plox2_reg  <= $signed({1'b0, tm1_reg[QL-1:0]}) * dx1_reg;
            ploy2_reg  <= $signed({1'b0, tm1_reg[QL-1:0]}) * dy1_reg;
            phix2_reg  <= $signed({1'b0, tm1_reg[QB-1:QL]}) * dx1_reg;
            phiy2_reg  <= $signed({1'b0, tm1_reg[QB-1:QL]}) * dy1_reg;
            neg2_reg   <= neg1_reg;
            wx2_reg    <= wx1_reg;
            wy2_reg    <= wy1_reg;
            bound2_reg <= bound1_reg;

            px3_reg    <= (RW'(phix2_reg) <<< QL) + RW'(plox2_reg);
            py3_reg    <= (RW'(phiy2_reg) <<< QL) + RW'(ploy2_reg);
            ox3_reg    <= -(RW'(wx2_reg) <<< T_FRAC);
            oy3_reg    <= -(RW'(wy2_reg) <<< T_FRAC);
            neg3_reg   <= neg2_reg;
            bound3_reg <= bound2_reg;

            rx4_reg    <= neg3_reg ? (ox3_reg - px3_reg) : (ox3_reg + px3_reg);
            ry4_reg    <= neg3_reg ? (oy3_reg - py3_reg) : (oy3_reg + py3_reg);
            bound4_reg <= bound3_reg;

            mx5_reg    <= mx5_next;
            my5_reg    <= my5_next;
            bound5_reg <= bound4_reg;

            sqx6_reg   <= mx5_reg * mx5_reg;
            sqy6_reg   <= my5_reg * my5_reg;
            bound6_reg <= bound5_reg;

            beat_reg.bound <= bound6_reg;
            beat_reg.rem   <= '0;
            beat_reg.root  <= '0;
            beat_reg.rad   <= RADB'(sum_next);
        end
    end

    assign valid = v_reg[6];
    assign beat  = beat_reg;

endmodule
`default_nettype wire

>>> rtl/core/psd_sqrt_stage.sv
`default_nettype none
module psd_sqrt_stage import psd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      prev_valid,
    input  wire psd_sqrt_t prev_beat,
    output logic           valid,
    output psd_sqrt_t      beat
);

    logic      valid_reg;
    psd_sqrt_t beat_reg;
    psd_sqrt_t beat_next;

    logic [RMW+1:0] r_ext;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           fits;

    // One root bit per stage: bring down two radicand bits and try 4*root+1.
    always_comb
    begin
        r_ext = {prev_beat.rem, prev_beat.rad[RADB-1:RADB-2]};
        trial = (RMW + 2)'({prev_beat.root, 2'b01});
        diff  = r_ext - trial;
        fits  = (r_ext >= trial);

        beat_next      = prev_beat;
        beat_next.rem  = fits ? RMW'(diff) : RMW'(r_ext);
        beat_next.root = {prev_beat.root[QS-2:0], fits};
        beat_next.rad  = {prev_beat.rad[RADB-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule
`default_nettype wire
